### design/rnf_pkg.sv
package rnf_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int OP_W          = 3;
    localparam int VALUE_W       = 32;
    localparam int CHAR_W        = 8;

    localparam logic [OP_W-1:0] OP_UDEC = 3'd0;
    localparam logic [OP_W-1:0] OP_SDEC = 3'd1;
    localparam logic [OP_W-1:0] OP_OCT  = 3'd2;
    localparam logic [OP_W-1:0] OP_HEX  = 3'd3;
    localparam logic [OP_W-1:0] OP_CHAR = 3'd4;

    localparam logic [CHAR_W-1:0] CHR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_X      = 8'h78;
    localparam logic [CHAR_W-1:0] CHR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_HEX_OF = 8'h37;

    typedef enum logic [2:0] {
        CS_ZERO  = 3'd0,
        CS_X     = 3'd1,
        CS_MINUS = 3'd2,
        CS_SPACE = 3'd3,
        CS_DIGIT = 3'd4,
        CS_RAW   = 3'd5
    } char_sel_t;

    typedef struct packed {
        logic      load;
        logic      conv_step;
        logic      ptr_dec;
        logic      emit;
        logic      last;
        char_sel_t ch_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            is_zero;
        logic            is_neg;
        logic            conv_last;
        logic            dig_zero;
        logic            ptr_zero;
        logic            emit_ok;
    } dp_sts_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = CHR_ZERO + {4'b0, d};
        end
        else
        begin
            c = CHR_HEX_OF + {4'b0, d};
        end
        return c;
    endfunction

endpackage

### design/rnf_ctrl.sv
module rnf_ctrl
    import rnf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DISP  = 9'b000000010,
        ST_XCHR  = 9'b000000100,
        ST_CONV  = 9'b000001000,
        ST_SKIP  = 9'b000010000,
        ST_DIGIT = 9'b000100000,
        ST_SPACE = 9'b001000000,
        ST_TAIL  = 9'b010000000,
        ST_RAW   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.ch_sel = CS_ZERO;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                if (sts.emit_ok)
                begin
                    case (sts.op)
                        OP_UDEC:
                        begin
                            if (sts.is_zero)
                            begin
                                cmd.emit   = 1'b1;
                                state_next = ST_SPACE;
                            end
                            else
                            begin
                                state_next = ST_CONV;
                            end
                        end
                        OP_SDEC:
                        begin
                            if (sts.is_zero)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.last   = 1'b1;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                cmd.emit   = sts.is_neg;
                                cmd.ch_sel = CS_MINUS;
                                state_next = ST_CONV;
                            end
                        end
                        OP_OCT:
                        begin
                            cmd.emit   = 1'b1;
                            state_next = sts.is_zero ? ST_TAIL : ST_SKIP;
                        end
                        OP_HEX:
                        begin
                            cmd.emit   = 1'b1;
                            state_next = ST_XCHR;
                        end
                        default:
                        begin
                            state_next = ST_RAW;
                        end
                    endcase
                end
            end
            ST_RAW:
            begin
                // Undefined codes fall in here along with the character code.
                if (sts.emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.ch_sel = CS_RAW;
                    state_next = ST_IDLE;
                end
            end
            ST_XCHR:
            begin
                if (sts.emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ch_sel = CS_X;
                    state_next = sts.is_zero ? ST_TAIL : ST_SKIP;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (sts.conv_last)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // A nonzero magnitude always has a nonzero top digit somewhere.
                if (sts.dig_zero)
                begin
                    cmd.ptr_dec = 1'b1;
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (sts.emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ch_sel = CS_DIGIT;
                    if (sts.ptr_zero)
                    begin
                        state_next = ST_SPACE;
                    end
                    else
                    begin
                        cmd.ptr_dec = 1'b1;
                    end
                end
            end
            ST_SPACE:
            begin
                if (sts.emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.ch_sel = CS_SPACE;
                    state_next = ST_IDLE;
                end
            end
            ST_TAIL:
            begin
                if (sts.emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/rnf_datapath.sv
module rnf_datapath
    import rnf_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [OP_W-1:0]     op,
    input  logic [VALUE_W-1:0]  value,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CHAR_W-1:0]   ch,
    output logic                last
);

    // Octal needs the most digits of the three radices.
    localparam int NDIG  = (WORD_BITS + 2) / 3;
    localparam int PTR_W = $clog2(NDIG);
    localparam int CNT_W = $clog2(WORD_BITS);

    logic [OP_W-1:0]      op_reg;
    logic                 zero_reg;
    logic                 neg_reg;
    logic [WORD_BITS-1:0] mag_reg;
    logic [WORD_BITS-1:0] mag_next;
    logic [CHAR_W-1:0]    raw_reg;
    logic [3:0]           dig_reg [NDIG];
    logic [3:0]           dig_next [NDIG];
    logic [PTR_W-1:0]     ptr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    ch_reg;
    logic                 last_reg;

    logic [WORD_BITS-1:0] word;
    logic                 word_neg;
    logic [NDIG*3-1:0]    oct_ext;
    logic [NDIG*4-1:0]    hex_ext;
    logic [NDIG*4-1:0]    bcd_adj;
    logic [NDIG*4-1:0]    bcd_shift;
    logic [CHAR_W-1:0]    ch_next;
    logic                 emit_ok;

    assign word     = WORD_BITS'(value);
    assign word_neg = (op == OP_SDEC) && word[WORD_BITS-1];
    assign oct_ext  = (NDIG*3)'(word);
    assign hex_ext  = (NDIG*4)'(word);

    // One double-dabble step: add three to every digit of five or more, then shift.
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            bcd_adj[i*4 +: 4] = (dig_reg[i] >= 4'd5) ? dig_reg[i] + 4'd3 : dig_reg[i];
        end
        bcd_shift = {bcd_adj[NDIG*4-2:0], mag_reg[WORD_BITS-1]};
    end

    always_comb
    begin
        mag_next = mag_reg;
        for (int i = 0; i < NDIG; i++)
        begin
            dig_next[i] = dig_reg[i];
        end
        if (cmd.load)
        begin
            mag_next = word_neg ? (~word + WORD_BITS'(1)) : word;
            for (int i = 0; i < NDIG; i++)
            begin
                if (op == OP_OCT)
                begin
                    dig_next[i] = {1'b0, oct_ext[i*3 +: 3]};
                end
                else if (op == OP_HEX)
                begin
                    dig_next[i] = hex_ext[i*4 +: 4];
                end
                else
                begin
                    dig_next[i] = 4'd0;
                end
            end
        end
        else if (cmd.conv_step)
        begin
            mag_next = {mag_reg[WORD_BITS-2:0], 1'b0};
            for (int i = 0; i < NDIG; i++)
            begin
                dig_next[i] = bcd_shift[i*4 +: 4];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        for (int i = 0; i < NDIG; i++)
        begin
            dig_reg[i] <= dig_next[i];
        end
        if (cmd.load)
        begin
            op_reg   <= op;
            zero_reg <= (word == '0);
            neg_reg  <= word_neg;
            raw_reg  <= value[CHAR_W-1:0];
        end
        if (cmd.emit)
        begin
            ch_reg   <= ch_next;
            last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                ptr_reg <= PTR_W'(NDIG - 1);
                cnt_reg <= '0;
            end
            else
            begin
                if (cmd.ptr_dec)
                begin
                    ptr_reg <= ptr_reg - PTR_W'(1);
                end
                if (cmd.conv_step)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        unique case (cmd.ch_sel)
            CS_ZERO:  ch_next = CHR_ZERO;
            CS_X:     ch_next = CHR_X;
            CS_MINUS: ch_next = CHR_MINUS;
            CS_SPACE: ch_next = CHR_SPACE;
            CS_DIGIT: ch_next = digit_char(dig_reg[ptr_reg]);
            CS_RAW:   ch_next = raw_reg;
            default:  ch_next = CHR_SPACE;
        endcase
    end

    assign emit_ok = !out_valid_reg || out_ready;

    assign sts.op        = op_reg;
    assign sts.is_zero   = zero_reg;
    assign sts.is_neg    = neg_reg;
    assign sts.conv_last = (cnt_reg == CNT_W'(WORD_BITS - 1));
    assign sts.dig_zero  = (dig_reg[ptr_reg] == 4'd0);
    assign sts.ptr_zero  = (ptr_reg == '0);
    assign sts.emit_ok   = emit_ok;

    assign out_valid = out_valid_reg;
    assign ch        = ch_reg;
    assign last      = last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && out_valid_reg |-> out_ready)
        else $error("character register overwritten while still held");

    a_ptr_floor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ptr_dec |-> ptr_reg != '0)
        else $error("digit pointer stepped below the lowest digit");

    a_digit_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.ch_sel == CS_DIGIT |-> !cmd.last)
        else $error("a digit was marked as the final character");

    a_conv_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.conv_step |-> (op_reg == OP_UDEC || op_reg == OP_SDEC))
        else $error("decimal conversion ran for a non-decimal code");

endmodule

### design/radix_number_formatter_core.sv
// One character per beat leaves the output register; a new item is taken once its last one is loaded.
// Raw character: acceptance, then the dispatch state, then the raw state loads the character.
// Nonzero octal and hex: acceptance, the prefix characters, then a walk down the digit
// positions that skips leading zeros, finds the top digit, emits each digit, then the space.
// Decimal first runs a double-dabble pass over the magnitude, then the same digit walk.
// Reset clears the controller and the output valid flag; the block accepts immediately after.
module radix_number_formatter_core
    import rnf_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    op,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  ch,
    output logic               last
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    rnf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rnf_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ch        (ch),
        .last      (last)
    );

endmodule

### test/radix_number_formatter_core_tb.sv
module radix_number_formatter_core_tb;
    import rnf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS  = 32;
    localparam int IDLE_LIMIT = 1000;
    localparam int RAND_ITEMS = 360;
    localparam int TAIL_WAIT  = 64;

    // Codes past the raw character code fall back to it.
    localparam logic [OP_W-1:0]   OP_UNDEF_LO = 3'd5;
    localparam logic [OP_W-1:0]   OP_UNDEF_HI = 3'd7;
    localparam logic [CHAR_W-1:0] CHR_UPPER_A = 8'h41;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        int                 gap;
        bit                 drain;
    } req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } glyph_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    op = '0;
    logic [VALUE_W-1:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CHAR_W-1:0]  ch;
    logic               last;

    req_t   req_q[$];
    glyph_t text_q[$];

    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    bit send_calm = 1'b0;
    bit sink_calm = 1'b0;
    int gap_cnt = 0;
    int stall_left = 0;
    int sink_draw;
    int idle_cycles = 0;
    int errors = 0;

    radix_number_formatter_core #(
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ch        (ch),
        .last      (last)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Appends the characters that one request should produce.
    function automatic void queue_text(input logic [OP_W-1:0] code,
                                       input logic [VALUE_W-1:0] word);
        logic [CHAR_W-1:0]  txt [0:15];
        logic [CHAR_W-1:0]  rev [0:31];
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [VALUE_W-1:0] rem;
        logic [3:0]         dig;
        int                 n;
        int                 k;
        glyph_t             g;
        n = 0;
        k = 0;
        radix = '0;
        mag = word;
        case (code)
            OP_UDEC:
            begin
                if (word == '0)
                begin
                    txt[0] = CHR_ZERO;
                    txt[1] = CHR_SPACE;
                    n = 2;
                end
                else
                begin
                    radix = 10;
                end
            end
            OP_SDEC:
            begin
                if (word == '0)
                begin
                    txt[0] = CHR_ZERO;
                    n = 1;
                end
                else
                begin
                    radix = 10;
                    if (word[WORD_BITS-1])
                    begin
                        txt[0] = CHR_MINUS;
                        n = 1;
                        mag = ~word + 1'b1;
                    end
                end
            end
            OP_OCT:
            begin
                txt[0] = CHR_ZERO;
                n = 1;
                if (word == '0)
                begin
                    txt[1] = CHR_ZERO;
                    n = 2;
                end
                else
                begin
                    radix = 8;
                end
            end
            OP_HEX:
            begin
                txt[0] = CHR_ZERO;
                txt[1] = CHR_X;
                n = 2;
                if (word == '0)
                begin
                    txt[2] = CHR_ZERO;
                    n = 3;
                end
                else
                begin
                    radix = 16;
                end
            end
            default:
            begin
                txt[0] = word[CHAR_W-1:0];
                n = 1;
            end
        endcase
        if (radix != '0)
        begin
            while (mag != '0)
            begin
                rem = mag % radix;
                dig = rem[3:0];
                rev[k] = (dig < 4'd10) ? CHR_ZERO + dig : CHR_UPPER_A + dig - 8'd10;
                mag = mag / radix;
                k++;
            end
            while (k > 0)
            begin
                k--;
                txt[n] = rev[k];
                n++;
            end
            txt[n] = CHR_SPACE;
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            g.ch = txt[i];
            g.last = (i == n - 1);
            text_q.push_back(g);
        end
    endfunction

    function automatic void add_req(input logic [OP_W-1:0] code,
                                    input logic [VALUE_W-1:0] word,
                                    input bit drain);
        req_t r;
        if ($urandom_range(0, 29) == 0)
        begin
            send_calm = ~send_calm;
        end
        r.op = code;
        r.value = word;
        r.gap = send_calm ? 0 : $urandom_range(0, 8);
        r.drain = drain;
        req_q.push_back(r);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 20);
            2: v = (32'h1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
            3: v = {1'b1, 31'($urandom)};
            4: v = ~32'($urandom_range(0, 20));
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        logic [OP_W-1:0] c;
        case ($urandom_range(0, 9))
            0, 1: c = OP_UDEC;
            2, 3: c = OP_SDEC;
            4, 5: c = OP_OCT;
            6, 7: c = OP_HEX;
            8: c = OP_CHAR;
            default: c = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        endcase
        return c;
    endfunction

    // Sender: sends once the prior beat is taken, its gap is over and any drain has ended.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (req_q.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (gap_cnt < req_q[0].gap || (req_q[0].drain && text_q.size() != 0))
            begin
                in_valid <= 1'b0;
                gap_cnt <= gap_cnt + 1;
            end
            else
            begin
                in_valid <= 1'b1;
                op <= req_q[0].op;
                value <= req_q[0].value;
                gap_cnt <= 0;
                void'(req_q.pop_front());
            end
        end
    end

    // Receiver: after each character, a random stall, possibly none, holds ready low.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    sink_calm = ~sink_calm;
                end
                sink_draw = sink_calm ? 0 : $urandom_range(0, 8);
                stall_left <= sink_draw;
                out_ready <= (sink_draw == 0);
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= (stall_left == 1);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            out_taken <= out_valid && out_ready;
            if (out_valid && out_ready)
            begin
                if (text_q.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("%0t: unexpected character ch=%h last=%b", $realtime, ch, last);
                    end
                    errors++;
                end
                else
                begin
                    if (ch !== text_q[0].ch || last !== text_q[0].last)
                    begin
                        if (errors < 10)
                        begin
                            $display("%0t: mismatch ch exp=%h got=%h, last exp=%b got=%b",
                                     $realtime, text_q[0].ch, ch, text_q[0].last, last);
                        end
                        errors++;
                    end
                    void'(text_q.pop_front());
                end
            end
            if (in_valid && in_ready)
            begin
                queue_text(op, value);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        // Directed: zero short forms, word extremes, every hex letter, the most
        // negative signed word and the codes that fall back to a raw character.
        add_req(OP_UDEC, 32'h0000_0000, 1'b0);
        add_req(OP_UDEC, 32'h0000_0001, 1'b0);
        add_req(OP_UDEC, 32'hFFFF_FFFF, 1'b0);
        add_req(OP_SDEC, 32'h0000_0000, 1'b0);
        add_req(OP_SDEC, 32'h0000_0001, 1'b0);
        add_req(OP_SDEC, 32'h7FFF_FFFF, 1'b0);
        add_req(OP_SDEC, 32'h8000_0000, 1'b0);
        add_req(OP_SDEC, 32'hFFFF_FFFF, 1'b0);
        add_req(OP_OCT, 32'h0000_0000, 1'b0);
        add_req(OP_OCT, 32'h0000_0007, 1'b0);
        add_req(OP_OCT, 32'hFFFF_FFFF, 1'b0);
        add_req(OP_HEX, 32'h0000_0000, 1'b0);
        add_req(OP_HEX, 32'hABCD_EF09, 1'b0);
        add_req(OP_HEX, 32'hFFFF_FFFF, 1'b0);
        add_req(OP_HEX, 32'h0000_0010, 1'b0);
        add_req(OP_CHAR, 32'h0000_0000, 1'b0);
        add_req(OP_CHAR, 32'hFFFF_FFFF, 1'b0);
        add_req(OP_UNDEF_LO, 32'h1234_5641, 1'b0);
        add_req(OP_UNDEF_LO + 3'd1, 32'h0000_00A5, 1'b0);
        add_req(OP_UNDEF_HI, 32'hFFFF_FF5A, 1'b0);
        // The first random request waits for the whole directed text to drain.
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            add_req(pick_op(), pick_value(), i == 0 || $urandom_range(0, 39) == 0);
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (req_q.size() != 0 || in_valid || text_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_WAIT) @(posedge clk);
        if (errors == 0 && text_q.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
